/* src/efcc_pkg.sv */
// ----------------------------------------------------------------------------
// efcc_pkg
// Shared types, constants and the CRC-8 word update for the encoder frame
// CRC checker.
// ----------------------------------------------------------------------------
`default_nettype none

package efcc_pkg;

   // Data words per frame between the discarded word and the safety word
   localparam int DATA_WORDS = 3;

   localparam int WORD_W      = 16;
   localparam int SCORE_W     = 14;
   localparam int CRC_W       = 8;
   localparam int OUT_WORDS   = 3;
   localparam int CSR_INDEX_W = 4;

   // Frame phase: idle, skip, DATA_WORDS data phases, safety
   localparam int PHASE_W = $clog2(DATA_WORDS + 3);

   localparam logic [CRC_W-1:0] CRC_POLY = 8'h1D;
   localparam logic [CRC_W-1:0] CRC_SEED = 8'hFF;

   // Bit of the safety word that flags a system error (active low)
   localparam int SYS_OK_BIT = 14;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_WORD = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_PENALTY  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_REWARD   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_LIMIT  = 4'd3;

   // Configuration reset values
   localparam logic [WORD_W-1:0]  RST_COMMAND_WORD = 16'h8023;
   localparam logic [SCORE_W-1:0] RST_CRC_PENALTY  = 14'd30;
   localparam logic [SCORE_W-1:0] RST_CRC_REWARD   = 14'd1;
   localparam logic [SCORE_W-1:0] RST_SCORE_LIMIT  = 14'd10000;

   typedef struct packed {
      logic [WORD_W-1:0]  command_word;
      logic [SCORE_W-1:0] crc_penalty;
      logic [SCORE_W-1:0] crc_reward;
      logic [SCORE_W-1:0] score_limit;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0]  angle_word;
      logic [WORD_W-1:0]  speed_word;
      logic [WORD_W-1:0]  revs_word;
      logic [WORD_W-1:0]  safety_word;
      logic               crc_bad;
      logic [SCORE_W-1:0] health_score;
      logic [WORD_W-1:0]  crc_error_total;
      logic [WORD_W-1:0]  system_error_total;
   } rsp_data_type;

   // CRC-8, MSB first, one 16-bit word high byte first
   function automatic logic [CRC_W-1:0] crc_word(input logic [CRC_W-1:0] crc,
                                                 input logic [WORD_W-1:0] word);
      logic [CRC_W-1:0] c;
      c = crc;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (c[CRC_W-1] ^ word[b]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/efcc_req_if.sv */
// ----------------------------------------------------------------------------
// efcc_req_if
// Input channel: one trigger or one received link word per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface efcc_req_if;
   import efcc_pkg::*;

   logic              valid;
   logic              ready;
   logic              func;
   logic [WORD_W-1:0] rx_word;

   modport source (output valid, func, rx_word, input ready);
   modport sink   (input valid, func, rx_word, output ready);
endinterface

`default_nettype wire

/* src/efcc_rsp_if.sv */
// ----------------------------------------------------------------------------
// efcc_rsp_if
// Result channel: one checked frame per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface efcc_rsp_if;
   import efcc_pkg::*;

   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  angle_word;
   logic [WORD_W-1:0]  speed_word;
   logic [WORD_W-1:0]  revs_word;
   logic [WORD_W-1:0]  safety_word;
   logic               crc_bad;
   logic [SCORE_W-1:0] health_score;
   logic [WORD_W-1:0]  crc_error_total;
   logic [WORD_W-1:0]  system_error_total;

   modport source (output valid, angle_word, speed_word, revs_word, safety_word,
                   crc_bad, health_score, crc_error_total, system_error_total,
                   input ready);
   modport sink   (input valid, angle_word, speed_word, revs_word, safety_word,
                   crc_bad, health_score, crc_error_total, system_error_total,
                   output ready);
endinterface

`default_nettype wire

/* src/efcc_csr.sv */
// ----------------------------------------------------------------------------
// efcc_csr
// Configuration registers: command word, penalty, reward and score limit.
// ----------------------------------------------------------------------------
`default_nettype none

module efcc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [efcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [efcc_pkg::WORD_W-1:0]      csr_wdata,
   output efcc_pkg::cfg_type                     cfg
);
   import efcc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COMMAND_WORD: cfg_in.command_word = csr_wdata;
            CSR_CRC_PENALTY:  cfg_in.crc_penalty  = csr_wdata[SCORE_W-1:0];
            CSR_CRC_REWARD:   cfg_in.crc_reward   = csr_wdata[SCORE_W-1:0];
            CSR_SCORE_LIMIT:  cfg_in.score_limit  = csr_wdata[SCORE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_word <= RST_COMMAND_WORD;
         cfg_ff.crc_penalty  <= RST_CRC_PENALTY;
         cfg_ff.crc_reward   <= RST_CRC_REWARD;
         cfg_ff.score_limit  <= RST_SCORE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* src/efcc_frame.sv */
// ----------------------------------------------------------------------------
// efcc_frame
// Input register and frame sequencer: CRC over command and data words,
// word capture, safety word check, health score and error counters.
// ----------------------------------------------------------------------------
`default_nettype none

module efcc_frame (
   input  wire logic           clock,
   input  wire logic           reset,
   efcc_req_if.sink            req_ch,
   input  efcc_pkg::cfg_type   cfg,
   input  wire logic           out_free,
   output logic                emit_valid,
   output efcc_pkg::rsp_data_type emit_data
);
   import efcc_pkg::*;

   localparam logic [PHASE_W-1:0] PH_IDLE   = PHASE_W'(0);
   localparam logic [PHASE_W-1:0] PH_SKIP   = PHASE_W'(1);
   localparam logic [PHASE_W-1:0] PH_DATA0  = PHASE_W'(2);
   localparam logic [PHASE_W-1:0] PH_SAFETY = PHASE_W'(DATA_WORDS + 2);

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_func_ff;
   logic [WORD_W-1:0] s1_word_ff;

   // Frame state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [WORD_W-1:0]  cap_ff [DATA_WORDS];
   logic [WORD_W-1:0]  cap_in [DATA_WORDS];
   logic [SCORE_W-1:0] illness_ff, illness_in;
   logic [WORD_W-1:0]  crc_cnt_ff, crc_cnt_in;
   logic [WORD_W-1:0]  sys_cnt_ff, sys_cnt_in;

   logic               is_safety;
   logic               s1_fire;
   logic               crc_bad;
   logic [SCORE_W:0]   score_sum;
   logic [WORD_W-1:0]  out_words [OUT_WORDS];

   // Advance the input stage unless a result waits for a full output register
   assign is_safety   = s1_func_ff && (phase_ff == PH_SAFETY);
   assign s1_fire     = s1_valid_ff && (!is_safety || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign s1_valid_in = req_ch.valid || (s1_valid_ff && !s1_fire);

   assign crc_bad   = s1_word_ff[CRC_W-1:0] != ~crc_ff;
   assign score_sum = {1'b0, illness_ff} + {1'b0, cfg.crc_penalty};

   // Sequence the frame
   always_comb begin
      phase_in   = phase_ff;
      crc_in     = crc_ff;
      cap_in     = cap_ff;
      illness_in = illness_ff;
      crc_cnt_in = crc_cnt_ff;
      sys_cnt_in = sys_cnt_ff;
      if (s1_fire) begin
         if (!s1_func_ff) begin
            // Trigger: only honored while idle
            if (phase_ff == PH_IDLE) begin
               crc_in   = crc_word(CRC_SEED, cfg.command_word);
               phase_in = PH_SKIP;
            end
         end else if (phase_ff == PH_IDLE) begin
            phase_in = PH_IDLE;
         end else if (phase_ff == PH_SKIP) begin
            phase_in = PH_DATA0;
         end else if (phase_ff < PH_SAFETY) begin
            for (int j = 0; j < DATA_WORDS; j++) begin
               if (phase_ff == PHASE_W'(j + 2)) begin
                  cap_in[j] = s1_word_ff;
               end
            end
            crc_in   = crc_word(crc_ff, s1_word_ff);
            phase_in = phase_ff + PHASE_W'(1);
         end else begin
            // Safety word: score, count and close the frame
            if (crc_bad) begin
               crc_cnt_in = crc_cnt_ff + WORD_W'(1);
               if (score_sum < {1'b0, cfg.score_limit}) begin
                  illness_in = score_sum[SCORE_W-1:0];
               end else begin
                  illness_in = cfg.score_limit;
               end
            end else if (illness_ff > cfg.crc_reward) begin
               illness_in = illness_ff - cfg.crc_reward;
            end else begin
               illness_in = '0;
            end
            if (!s1_word_ff[SYS_OK_BIT]) begin
               sys_cnt_in = sys_cnt_ff + WORD_W'(1);
            end
            phase_in = PH_IDLE;
            crc_in   = CRC_SEED;
         end
      end
   end

   // Map captured words onto the three output fields; missing ones read zero
   always_comb begin
      for (int i = 0; i < OUT_WORDS; i++) begin
         out_words[i] = '0;
         for (int j = 0; j < DATA_WORDS; j++) begin
            if (i == j) begin
               out_words[i] = cap_ff[j];
            end
         end
      end
   end

   assign emit_valid = s1_fire && is_safety;

   always_comb begin
      emit_data.angle_word         = out_words[0];
      emit_data.speed_word         = out_words[1];
      emit_data.revs_word          = out_words[2];
      emit_data.safety_word        = s1_word_ff;
      emit_data.crc_bad            = crc_bad;
      emit_data.health_score       = illness_in;
      emit_data.crc_error_total    = crc_cnt_in;
      emit_data.system_error_total = sys_cnt_in;
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_func_ff <= req_ch.func;
         s1_word_ff <= req_ch.rx_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         crc_ff      <= CRC_SEED;
         illness_ff  <= '0;
         crc_cnt_ff  <= '0;
         sys_cnt_ff  <= '0;
         for (int j = 0; j < DATA_WORDS; j++) begin
            cap_ff[j] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         phase_ff    <= phase_in;
         crc_ff      <= crc_in;
         illness_ff  <= illness_in;
         crc_cnt_ff  <= crc_cnt_in;
         sys_cnt_ff  <= sys_cnt_in;
         cap_ff      <= cap_in;
      end
   end

   // A closed frame leaves the sequencer idle with a fresh seed
   a_close_frame : assert property (@(posedge clock) disable iff (reset)
      emit_valid |=> (phase_ff == PH_IDLE) && (crc_ff == CRC_SEED))
      else $error("frame not closed after safety word");

   // A CRC mismatch bumps the error count by exactly one
   a_crc_count : assert property (@(posedge clock) disable iff (reset)
      (emit_valid && crc_bad) |=> crc_cnt_ff == $past(crc_cnt_ff) + WORD_W'(1))
      else $error("CRC error count did not advance");

   // The score moves only when a safety word is processed
   a_score_hold : assert property (@(posedge clock) disable iff (reset)
      !emit_valid |=> $stable(illness_ff))
      else $error("health score changed outside a safety word");

   // A stalled input item never reaches the sequencer twice
   a_no_stall_fire : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && is_safety && !out_free) |=> $stable(crc_cnt_ff)
         && $stable(sys_cnt_ff))
      else $error("counters moved while the result was stalled");

endmodule

`default_nettype wire

/* src/efcc_out.sv */
// ----------------------------------------------------------------------------
// efcc_out
// Result register: holds one checked frame until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module efcc_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              emit_valid,
   input  efcc_pkg::rsp_data_type emit_data,
   output logic                   out_free,
   efcc_rsp_if.source             rsp_ch
);
   import efcc_pkg::*;

   logic         valid_ff, valid_in;
   rsp_data_type data_ff;

   // Free when empty or when the held item leaves this cycle
   assign out_free = !valid_ff || rsp_ch.ready;
   assign valid_in = emit_valid || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new result item
   always_ff @(posedge clock) begin
      if (emit_valid) begin
         data_ff <= emit_data;
      end
   end

   assign rsp_ch.valid              = valid_ff;
   assign rsp_ch.angle_word         = data_ff.angle_word;
   assign rsp_ch.speed_word         = data_ff.speed_word;
   assign rsp_ch.revs_word          = data_ff.revs_word;
   assign rsp_ch.safety_word        = data_ff.safety_word;
   assign rsp_ch.crc_bad            = data_ff.crc_bad;
   assign rsp_ch.health_score       = data_ff.health_score;
   assign rsp_ch.crc_error_total    = data_ff.crc_error_total;
   assign rsp_ch.system_error_total = data_ff.system_error_total;

endmodule

`default_nettype wire

/* src/encoder_frame_crc_checker.sv */
// ----------------------------------------------------------------------------
// encoder_frame_crc_checker
// Sensor read frame checker with CRC-8 (poly 0x1D, seed 0xFF), health score
// and error counters.
// ----------------------------------------------------------------------------
// Takes one item per clock while the input is not stalled: a trigger
// (func 0) or a received link word (func 1). Each item is registered in
// the input register on acceptance and processed from there by a CRC-8
// update of one 16-bit word; the safety word of a frame produces one
// result item, which passes into an output register and is held there
// until taken. The input stays open while a result waits, and only stalls
// when a second safety word meets a full output register. Configuration
// writes are registered and must be made while no frame is in flight.
`default_nettype none

module encoder_frame_crc_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   efcc_req_if.sink                              req_ch,
   efcc_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [efcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [efcc_pkg::WORD_W-1:0]      csr_wdata
);
   import efcc_pkg::*;

   cfg_type      cfg;
   logic         out_free;
   logic         emit_valid;
   rsp_data_type emit_data;

   efcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   efcc_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_data  (emit_data)
   );

   efcc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit_valid (emit_valid),
      .emit_data  (emit_data),
      .out_free   (out_free),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
